// ===== src/igta_pkg.sv =====
// Package: shared types and constants for the gyro/accel time aligner.
`default_nettype none
package igta_pkg;
   localparam int TIME_W   = 48;
   localparam int AXIS_W   = 32;
   localparam int WGT_W    = 64;                // weights and span, wrapping
   localparam int PROD_W   = WGT_W + AXIS_W;    // magnitude product width
   localparam int MIX_W    = PROD_W + 1;        // sum of two products
   localparam int MAX_RUN  = 16;
   localparam logic OP_GYRO  = 1'b0;
   localparam logic OP_ACCEL = 1'b1;

   typedef logic [TIME_W-1:0] time_type;
   typedef logic [AXIS_W-1:0] axis_type;
   typedef logic [WGT_W-1:0]  wgt_type;
endpackage
`default_nettype wire

// ===== src/imu_gyro_accel_time_aligner.sv =====
// Top level: gyro FIFO and bit-serial accel interpolation between accel samples.
//
//  channel | direction | tdata (low bit up)                         | tuser / tlast
//  req     | in        | sample_time, axis_x, axis_y, axis_z        | tuser: operation
//  rsp     | out       | aligned_time, rate_x/y/z, accel_x/y/z      | tlast: last_of_run
//
// A gyro item is written to the FIFO if it has room. An accel item prunes old
// gyro entries, each through the PRUNE and LOOK states, then for each qualifying
// entry runs, per axis, two bit-serial multiplies and a restoring divide.
// The multiplier is shift-add and the divider gives one quotient bit a cycle.
// Reset clears FIFO pointers and the previous-accel state; FIFO data has none.
// A result waits in the output register; the next is not loaded until it is taken.
`default_nettype none
module imu_gyro_accel_time_aligner
   import igta_pkg::*;
#(
   parameter int FIFO_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // sample_time[47:0], axis_x[79:48], axis_y[111:80], axis_z[143:112]
   input  wire logic [143:0] req_tdata,
   // operation[0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // aligned_time[47:0], rate_x/y/z[143:48], accel_x/y/z[239:144]
   output logic [239:0]      rsp_tdata,
   output logic              rsp_tlast
);
   localparam int PW = $clog2(FIFO_DEPTH);
   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam int BW = $clog2(MIX_W + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRUNE = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // FIFO memory
   time_type gt_mem [FIFO_DEPTH];
   axis_type gx_mem [FIFO_DEPTH];
   axis_type gy_mem [FIFO_DEPTH];
   axis_type gz_mem [FIFO_DEPTH];

   logic [2:0]    state_ff, state_in;
   logic [PW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          pvalid_ff, pvalid_in;
   time_type      ptime_ff, ptime_in;
   axis_type      pacc_ff [3];
   axis_type      pacc_in [3];
   time_type      ntime_ff, ntime_in;
   axis_type      nacc_ff [3];
   axis_type      nacc_in [3];
   logic [4:0]    nrun_ff, nrun_in;
   logic [1:0]    axis_ff, axis_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic [0:0]    mulsel_ff, mulsel_in;     // 0: prev product, 1: new product
   // registered head read, and the time of the entry behind the head
   time_type      hg_ff;
   axis_type      hx_ff, hy_ff, hz_ff;
   time_type      hn_ff;
   // serial multiplier / divider
   logic [AXIS_W-1:0] mcand_ff, mcand_in;   // magnitude, shifted right
   logic [PROD_W-1:0] macc_ff, macc_in;
   logic [PROD_W-1:0] mmul_ff, mmul_in;     // weight, shifted left
   logic [PROD_W-1:0] p0_ff, p0_in;
   logic [MIX_W-1:0]  num_ff, num_in;
   logic              neg_ff, neg_in;
   logic [WGT_W-1:0]  rem_ff, rem_in;
   logic [AXIS_W-1:0] quo_ff, quo_in;
   axis_type          res_ff [3];
   axis_type          res_in [3];
   // output register
   logic              ovalid_ff, ovalid_in;
   logic [239:0]      odata_ff, odata_in;
   logic              olast_ff, olast_in;

   logic     req_fire, gyro_wr;
   logic [PW-1:0] tail, head_nx, ahead_nx;
   wgt_type  w_prev, w_new, span;
   axis_type a_sel, a_mag;
   logic     a_neg;
   logic [WGT_W-1:0] rem_sh;

   function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] v);
      logic [PW:0] s;
      s = {1'b0, v} + 1'b1;
      if (s >= (PW+1)'(FIFO_DEPTH)) s = '0;
      return s[PW-1:0];
   endfunction

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign gyro_wr    = req_fire && (req_tuser[0] == OP_GYRO) &&
                       (count_ff < CW'(FIFO_DEPTH));
   always_comb begin
      logic [PW:0] t;
      t = {1'b0, head_ff} + {1'b0, count_ff[PW-1:0]};
      if (t >= (PW+1)'(FIFO_DEPTH)) t = t - (PW+1)'(FIFO_DEPTH);
      tail = t[PW-1:0];
   end
   assign head_nx  = wrap_inc(head_ff);
   assign ahead_nx = wrap_inc(head_in);

   // weights and span wrap at 64 bits when times run backward
   assign span   = {16'd0, ntime_ff} - {16'd0, ptime_ff};
   assign w_prev = {16'd0, ntime_ff} - {16'd0, hg_ff};
   assign w_new  = {16'd0, hg_ff} - {16'd0, ptime_ff};
   assign a_sel  = mulsel_ff[0] ? nacc_ff[axis_ff] : pacc_ff[axis_ff];
   assign a_neg  = a_sel[AXIS_W-1];
   assign a_mag  = a_neg ? (~a_sel + 1'b1) : a_sel;
   // drop the remainder's top bit on the shift, as a 64-bit register would
   assign rem_sh = {rem_ff[WGT_W-2:0], num_ff[MIX_W-1]};

   // FIFO write and registered head read
   always_ff @(posedge clock) begin
      if (gyro_wr) begin
         gt_mem[tail] <= req_tdata[47:0];
         gx_mem[tail] <= req_tdata[79:48];
         gy_mem[tail] <= req_tdata[111:80];
         gz_mem[tail] <= req_tdata[143:112];
      end
      hg_ff <= gt_mem[head_in];
      hx_ff <= gx_mem[head_in];
      hy_ff <= gy_mem[head_in];
      hz_ff <= gz_mem[head_in];
      hn_ff <= gt_mem[ahead_nx];
   end

   always_comb begin
      state_in = state_ff;  head_in = head_ff;  count_in = count_ff;
      pvalid_in = pvalid_ff; ptime_in = ptime_ff; pacc_in = pacc_ff;
      ntime_in = ntime_ff;  nacc_in = nacc_ff;  nrun_in = nrun_ff;
      axis_in = axis_ff;    bit_in = bit_ff;    mulsel_in = mulsel_ff;
      mcand_in = mcand_ff;  macc_in = macc_ff;  mmul_in = mmul_ff;
      p0_in = p0_ff;        num_in = num_ff;    neg_in = neg_ff;
      rem_in = rem_ff;      quo_in = quo_ff;    res_in = res_ff;
      ovalid_in = ovalid_ff; odata_in = odata_ff; olast_in = olast_ff;
      if (ovalid_ff && rsp_tready) ovalid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (gyro_wr) count_in = count_ff + 1'b1;
            if (req_fire && req_tuser[0] == OP_ACCEL) begin
               ntime_in   = req_tdata[47:0];
               nacc_in[0] = req_tdata[79:48];
               nacc_in[1] = req_tdata[111:80];
               nacc_in[2] = req_tdata[143:112];
               nrun_in    = '0;
               if (pvalid_ff) state_in = ST_PRUNE;
               else begin
                  pvalid_in = 1'b1;
                  ptime_in  = req_tdata[47:0];
                  pacc_in   = nacc_in;
               end
            end
         end
         ST_PRUNE: begin
            // hg_ff holds the head entry, read last cycle
            if (count_ff != '0 && hg_ff < ptime_ff) begin
               head_in  = head_nx;
               count_in = count_ff - 1'b1;
               state_in = ST_LOOK;   // let the new head read settle
            end else state_in = ST_LOOK;
         end
         ST_LOOK: begin
            // prune only before the first result of the run
            if (nrun_ff == '0 && count_ff != '0 && hg_ff < ptime_ff) state_in = ST_PRUNE;
            else if (nrun_ff < 5'(MAX_RUN) && count_ff != '0 && hg_ff < ntime_ff) begin
               axis_in = 2'd0; mulsel_in = 1'b0; bit_in = '0;
               macc_in = '0; mcand_in = '0; mmul_in = '0;
               state_in = ST_MUL;
               neg_in = 1'b0;
               // load first operand pair on entry
               bit_in = BW'(AXIS_W + 1);
            end else begin
               ptime_in = ntime_ff;
               pacc_in  = nacc_ff;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            // count down: AXIS_W+1 loads the operands, then one bit a cycle
            if (bit_ff == BW'(AXIS_W + 1)) begin
               mcand_in = a_mag;
               mmul_in  = PROD_W'(mulsel_ff[0] ? w_new : w_prev);
               macc_in  = '0;
               bit_in   = BW'(AXIS_W);
            end else if (bit_ff != '0) begin
               if (mcand_ff[0]) macc_in = macc_ff + mmul_ff;
               mmul_in  = mmul_ff << 1;
               mcand_in = mcand_ff >> 1;
               bit_in   = bit_ff - 1'b1;
            end else if (mulsel_ff == 1'b0) begin
               p0_in     = macc_ff;
               neg_in    = a_neg;
               mulsel_in = 1'b1;
               bit_in    = BW'(AXIS_W + 1);
            end else begin
               // combine signed magnitudes
               if (neg_ff == a_neg) num_in = {1'b0, p0_ff} + {1'b0, macc_ff};
               else if (p0_ff >= macc_ff) num_in = {1'b0, p0_ff - macc_ff};
               else begin
                  num_in = {1'b0, macc_ff - p0_ff};
                  neg_in = a_neg;
               end
               rem_in   = '0;
               quo_in   = '0;
               bit_in   = BW'(MIX_W);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (bit_ff != '0) begin
               num_in = num_ff << 1;
               if (rem_sh >= span) begin
                  rem_in = rem_sh - span;
                  quo_in = {quo_ff[AXIS_W-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[AXIS_W-2:0], 1'b0};
               end
               bit_in = bit_ff - 1'b1;
            end else begin
               res_in[axis_ff] = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
               if (axis_ff == 2'd2) state_in = ST_OUT;
               else begin
                  axis_in   = axis_ff + 1'b1;
                  mulsel_in = 1'b0;
                  bit_in    = BW'(AXIS_W + 1);
                  state_in  = ST_MUL;
               end
            end
         end
         ST_OUT: begin
            if (!ovalid_in) begin
               ovalid_in = 1'b1;
               odata_in  = {res_ff[2], res_ff[1], res_ff[0], hz_ff, hy_ff, hx_ff, hg_ff};
               head_in   = head_nx;
               count_in  = count_ff - 1'b1;
               nrun_in   = nrun_ff + 1'b1;
               state_in  = ST_LOOK;
               // end the run unless the entry behind the head qualifies too and MAX_RUN is not reached
               olast_in  = !(nrun_ff < 5'(MAX_RUN - 1) && count_ff > CW'(1) &&
                             hn_ff < ntime_ff);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; head_ff <= '0; count_ff <= '0;
         pvalid_ff <= 1'b0; ptime_ff <= '0; pacc_ff <= '{default: '0};
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; count_ff <= count_in;
         pvalid_ff <= pvalid_in; ptime_ff <= ptime_in; pacc_ff <= pacc_in;
         ovalid_ff <= ovalid_in;
      end
      ntime_ff <= ntime_in; nacc_ff <= nacc_in; nrun_ff <= nrun_in;
      axis_ff <= axis_in; bit_ff <= bit_in; mulsel_ff <= mulsel_in;
      mcand_ff <= mcand_in; macc_ff <= macc_in; mmul_ff <= mmul_in;
      p0_ff <= p0_in; num_ff <= num_in; neg_ff <= neg_in;
      rem_ff <= rem_in; quo_ff <= quo_in; res_ff <= res_in;
      odata_ff <= odata_in; olast_ff <= olast_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tlast  = olast_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(FIFO_DEPTH)) else $error("fifo count overflow");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready) else $error("accept while busy");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");
endmodule
`default_nettype wire
